// File: hw/rtl/rig_pkg.sv
// Shared types and constants for the radical inverse generator.
// Used by rig_cell and radical_inverse_generator; depends on nothing.
package rig_pkg;

  localparam int SAMPLE_W = 24;
  localparam int FRAC_W   = 32;
  localparam int RADIX_W  = 5;
  localparam int DIGIT_W  = 4;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd2;

  typedef struct packed {
    logic valid;
    logic carry;
  } up_msg_t;

  typedef struct packed {
    logic valid;
    logic sel;
    logic bit_q;
  } dn_msg_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_WAIT = 4'b1000
  } state_t;

endpackage

// File: hw/rtl/rig_cell.sv
// One digit cell of the chain: converts binary to base-b digits on the up path
// and runs one bit-serial long-division step per cycle on the down path. Uses rig_pkg.
module rig_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clr,
  input  logic [rig_pkg::RADIX_W-1:0]   base,
  input  rig_pkg::up_msg_t              up_in,
  output rig_pkg::up_msg_t              up_out,
  input  rig_pkg::dn_msg_t              dn_in,
  output rig_pkg::dn_msg_t              dn_out
);

  logic [rig_pkg::DIGIT_W-1:0] digit_r, digit_nxt;
  logic [rig_pkg::DIGIT_W-1:0] rem_r, rem_nxt;
  rig_pkg::up_msg_t            up_r, up_nxt;
  rig_pkg::dn_msg_t            dn_r, dn_nxt;
  logic [rig_pkg::DIGIT_W-1:0] operand;
  logic                        in_bit;
  logic [rig_pkg::RADIX_W-1:0] trial;
  logic                        ge;
  logic [rig_pkg::RADIX_W-1:0] diff;

  always_comb begin
    operand = up_in.valid ? digit_r : rem_r;
    if (up_in.valid) begin
      in_bit = up_in.carry;
    end else if (dn_in.sel) begin
      in_bit = digit_r[rig_pkg::DIGIT_W-1];
    end else begin
      in_bit = dn_in.bit_q;
    end
    trial = {operand, in_bit};
    ge    = (trial >= base);
    diff  = ge ? (trial - base) : trial;

    digit_nxt = digit_r;
    rem_nxt   = rem_r;
    if (clr) begin
      digit_nxt = '0;
      rem_nxt   = '0;
    end else if (up_in.valid) begin
      digit_nxt = diff[rig_pkg::DIGIT_W-1:0];
    end else if (dn_in.valid) begin
      rem_nxt = diff[rig_pkg::DIGIT_W-1:0];
      if (dn_in.sel) begin
        digit_nxt = {digit_r[rig_pkg::DIGIT_W-2:0], 1'b0};
      end
    end

    up_nxt.valid = up_in.valid;
    up_nxt.carry = up_in.valid & ge;
    dn_nxt.valid = dn_in.valid;
    dn_nxt.sel   = dn_in.valid & dn_in.sel;
    dn_nxt.bit_q = dn_in.valid & ge;
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
    rem_r   <= rem_nxt;
    if (!rst_n) begin
      up_r <= '0;
      dn_r <= '0;
    end else begin
      up_r <= up_nxt;
      dn_r <= dn_nxt;
    end
  end

  assign up_out = up_r;
  assign dn_out = dn_r;

endmodule

// File: hw/rtl/radical_inverse_generator.sv
// A start is taken only in idle; busy stays high while the cell chain converts and divides.
// The cell chain sets the length: base conversion first, then the skewed bit-serial division.
// Synchronous active-low reset returns the radix to 2 and the controller to idle.
// The receiver cannot stall; each result is shown for one cycle. Uses rig_pkg and rig_cell.
module radical_inverse_generator #(
  parameter int INDEX_BITS    = 24,
  parameter int FRACTION_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [rig_pkg::SAMPLE_W-1:0]  in_sample_index,
  output logic                          out_strobe,
  output logic [rig_pkg::FRAC_W-1:0]    out_fraction,
  input  logic                          cfg_we,
  input  logic [rig_pkg::RADIX_W-1:0]   cfg_wdata
);

  localparam int NCELLS   = INDEX_BITS;
  localparam int CONV_END = INDEX_BITS + NCELLS - 1;
  localparam int DIV_END  = FRACTION_BITS + rig_pkg::DIGIT_W - 1;
  localparam int CNT_W    = $clog2(CONV_END + DIV_END + 2);

  rig_pkg::state_t               state_r, state_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [INDEX_BITS-1:0]         n_r, n_nxt;
  logic [FRACTION_BITS-1:0]      acc_r, acc_nxt;
  logic                          dv_prev_r;
  logic                          out_strobe_r, out_strobe_nxt;
  logic [rig_pkg::FRAC_W-1:0]    out_fraction_r, out_fraction_nxt;
  logic [rig_pkg::RADIX_W-1:0]   radix_r;
  logic [rig_pkg::RADIX_W-1:0]   base;
  logic                          accept;
  logic                          done;

  rig_pkg::up_msg_t up_link [NCELLS+1];
  rig_pkg::dn_msg_t dn_link [NCELLS+1];

  always_comb begin
    if (radix_r < rig_pkg::RADIX_MIN) begin
      base = rig_pkg::RADIX_MIN;
    end else if (radix_r > rig_pkg::RADIX_MAX) begin
      base = rig_pkg::RADIX_MAX;
    end else begin
      base = radix_r;
    end
  end

  assign accept = start && (state_r == rig_pkg::ST_IDLE);
  assign busy   = (state_r != rig_pkg::ST_IDLE);
  assign done   = (state_r == rig_pkg::ST_WAIT) && dv_prev_r && !dn_link[0].valid;

  assign up_link[0].valid = (state_r == rig_pkg::ST_CONV) && (cnt_r < CNT_W'(INDEX_BITS));
  assign up_link[0].carry = up_link[0].valid & n_r[INDEX_BITS-1];
  assign dn_link[NCELLS].valid = (state_r == rig_pkg::ST_DIV);
  assign dn_link[NCELLS].sel   = (state_r == rig_pkg::ST_DIV) &&
                                 (cnt_r < CNT_W'(rig_pkg::DIGIT_W));
  assign dn_link[NCELLS].bit_q = 1'b0;

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    rig_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .clr    (accept),
      .base   (base),
      .up_in  (up_link[i]),
      .up_out (up_link[i+1]),
      .dn_in  (dn_link[i+1]),
      .dn_out (dn_link[i])
    );
  end

  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    n_nxt            = n_r;
    acc_nxt          = acc_r;
    out_strobe_nxt   = 1'b0;
    out_fraction_nxt = out_fraction_r;
    if (dn_link[0].valid) begin
      acc_nxt = {acc_r[FRACTION_BITS-2:0], dn_link[0].bit_q};
    end
    case (state_r)
      rig_pkg::ST_IDLE: begin
        if (start) begin
          n_nxt     = INDEX_BITS'(in_sample_index);
          cnt_nxt   = '0;
          state_nxt = rig_pkg::ST_CONV;
        end
      end
      rig_pkg::ST_CONV: begin
        n_nxt   = {n_r[INDEX_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(CONV_END)) begin
          cnt_nxt   = '0;
          state_nxt = rig_pkg::ST_DIV;
        end
      end
      rig_pkg::ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_END)) begin
          state_nxt = rig_pkg::ST_WAIT;
        end
      end
      rig_pkg::ST_WAIT: begin
        if (done) begin
          out_strobe_nxt   = 1'b1;
          out_fraction_nxt = rig_pkg::FRAC_W'(acc_r);
          state_nxt        = rig_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rig_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cnt_r          <= cnt_nxt;
    n_r            <= n_nxt;
    acc_r          <= acc_nxt;
    out_fraction_r <= out_fraction_nxt;
    if (!rst_n) begin
      state_r      <= rig_pkg::ST_IDLE;
      dv_prev_r    <= 1'b0;
      out_strobe_r <= 1'b0;
      radix_r      <= rig_pkg::RADIX_RESET;
    end else begin
      state_r      <= state_nxt;
      dv_prev_r    <= dn_link[0].valid;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        radix_r <= cfg_wdata;
      end
    end
  end

  assign out_strobe   = out_strobe_r;
  assign out_fraction = out_fraction_r;

endmodule
